// ----- rtl/core/periodic_timer_bank_assert.svh -----
// -----------------------------------------------------------------------------
// periodic_timer_bank_assert.svh
// Assertion macros used by the timer bank checker.
// -----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_BANK_ASSERT_SVH
`define PERIODIC_TIMER_BANK_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define PTB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptb check failed");

// next-cycle implication, quiet while reset is high
`define PTB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptb check failed");

// next-cycle implication that also holds across reset
`define PTB_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ptb check failed");

`endif

// ----- rtl/core/ptb_pkg.sv -----
// -----------------------------------------------------------------------------
// ptb_pkg
// Types and constants for the periodic timer bank.
// -----------------------------------------------------------------------------
`default_nettype none

package ptb_pkg;

  localparam int DEF_NSLOTS = 16;
  localparam int SLOT_W     = 4;
  localparam int MS_W       = 24;
  localparam int TAG_W      = 32;
  localparam int TICK_W     = 21;
  localparam int TCNT_W     = 32;
  localparam int CMDQ_DEPTH = 2;
  localparam int CFG_IDX_W  = 1;

  localparam logic [MS_W-1:0] MIN_PERIOD_RESET = 24'd10;
  localparam logic [MS_W-1:0] MAX_PERIOD_RESET = 24'hFF_FFFF;

  // rounding offset and reciprocal of ten for (ms + 5) / 10
  localparam logic [MS_W:0] ROUND_ADD   = 25'd5;
  localparam logic [31:0]   RECIP10     = 32'hCCCC_CCCD;
  localparam int            RECIP_SHIFT = 35;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_REG   = 2'd1;
  localparam logic [1:0] OP_UNREG = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_REG,
    CMD_UNREG
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [SLOT_W-1:0]  slot;
    logic [TICK_W-1:0]  ticks;
    logic [TAG_W-1:0]   tag;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/periodic_timer_bank.sv -----
// -----------------------------------------------------------------------------
// periodic_timer_bank
// Bank of periodic timers on a 10 ms tick with register, unregister and
// tick requests; one result per expiring slot.
// -----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  request   | start / busy         | operation, slot, period_ms, tag
//  result    | fired (strobe)       | fired_slot, fired_tag, tick_count, last
//  config    | cfg_write            | cfg_index, cfg_data
//
//  A request is taken when start is high and busy low; busy stays high while
//  the period conversion result waits to enter the command queue, so it also
//  holds while the queue is full. Register and unregister run from the idle
//  state; a tick starts a walk of the active slots through the per-slot RAMs,
//  one slot per cycle. Results appear one per cycle at most, each for a single
//  cycle. Reset is synchronous and clears all control state.
// -----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_bank import ptb_pkg::*; #(
  parameter int NSLOTS = DEF_NSLOTS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           operation,
  input  wire logic [SLOT_W-1:0]    slot,
  input  wire logic [MS_W-1:0]      period_ms,
  input  wire logic [TAG_W-1:0]     tag,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MS_W-1:0]      cfg_data,
  output logic                      fired,
  output logic [SLOT_W-1:0]         fired_slot,
  output logic [TAG_W-1:0]          fired_tag,
  output logic [TCNT_W-1:0]         tick_count,
  output logic                      last
);

  logic [MS_W-1:0] min_period_ms;
  logic [MS_W-1:0] max_period_ms;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  cmd_t            q_in;
  cmd_t            q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_period_ms <= MIN_PERIOD_RESET;
      max_period_ms <= MAX_PERIOD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_PERIOD: min_period_ms <= cfg_data;
        REG_MAX_PERIOD: max_period_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ptb_front #(.NSLOTS(NSLOTS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .slot          (slot),
    .period_ms     (period_ms),
    .tag           (tag),
    .min_period_ms (min_period_ms),
    .max_period_ms (max_period_ms),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  ptb_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  ptb_back #(.NSLOTS(NSLOTS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (!q_empty),
    .cmd        (q_out),
    .cmd_pop    (q_pop),
    .fired      (fired),
    .fired_slot (fired_slot),
    .fired_tag  (fired_tag),
    .tick_count (tick_count),
    .last       (last)
  );

endmodule

`default_nettype wire

// ----- rtl/core/ptb_ram.sv -----
// -----------------------------------------------------------------------------
// ptb_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// -----------------------------------------------------------------------------
`default_nettype none

module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic [WIDTH-1:0]        wdata,
  input  wire logic [AW-1:0]           raddr,
  output logic      [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/ptb_front.sv -----
// -----------------------------------------------------------------------------
// ptb_front
// Request intake: filters ignored requests, clamps the period and converts
// milliseconds to 10 ms ticks, then pushes a command into the queue.
// -----------------------------------------------------------------------------
`default_nettype none

module ptb_front import ptb_pkg::*; #(
  parameter int NSLOTS = DEF_NSLOTS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        operation,
  input  wire logic [SLOT_W-1:0] slot,
  input  wire logic [MS_W-1:0]   period_ms,
  input  wire logic [TAG_W-1:0]  tag,
  input  wire logic [MS_W-1:0]   min_period_ms,
  input  wire logic [MS_W-1:0]   max_period_ms,
  input  wire logic              q_full,
  output logic                   q_push,
  output cmd_t                   q_data
);

  localparam int PROD_W = MS_W + 1 + 32;

  logic              a_valid;
  cmd_kind_t         a_kind;
  logic [SLOT_W-1:0] a_slot;
  logic [MS_W:0]     a_sum;
  logic [TAG_W-1:0]  a_tag;

  logic              accept;
  logic              keep;
  logic              slot_ok;
  cmd_kind_t         kind;
  logic [MS_W-1:0]   ms_clamped;
  logic [PROD_W-1:0] prod;

  assign slot_ok = 32'(slot) < 32'(NSLOTS);
  assign accept  = start && !a_valid;

  always_comb begin
    keep = 1'b0;
    kind = CMD_TICK;
    unique case (operation)
      OP_TICK: begin
        keep = 1'b1;
        kind = CMD_TICK;
      end
      OP_REG: begin
        keep = slot_ok;
        kind = CMD_REG;
      end
      OP_UNREG: begin
        keep = slot_ok;
        kind = CMD_UNREG;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // max is tested first, so crossed bounds give max for large requests
  always_comb begin
    if (period_ms > max_period_ms) begin
      ms_clamped = max_period_ms;
    end else if (period_ms < min_period_ms) begin
      ms_clamped = min_period_ms;
    end else begin
      ms_clamped = period_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept && keep) begin
      a_valid <= 1'b1;
    end else if (q_push) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_kind <= kind;
      a_slot <= slot;
      a_sum  <= {1'b0, ms_clamped} + ROUND_ADD;
      a_tag  <= tag;
    end
  end

  assign prod = {32'd0, a_sum} * {{(MS_W + 1){1'b0}}, RECIP10};

  assign busy        = a_valid;
  assign q_push      = a_valid && !q_full;
  assign q_data.kind  = a_kind;
  assign q_data.slot  = a_slot;
  assign q_data.ticks = prod[RECIP_SHIFT +: TICK_W];
  assign q_data.tag   = a_tag;

endmodule

`default_nettype wire

// ----- rtl/core/ptb_cmd_fifo.sv -----
// -----------------------------------------------------------------------------
// ptb_cmd_fifo
// Short command queue between the intake and the slot engine.
// -----------------------------------------------------------------------------
`default_nettype none

module ptb_cmd_fifo import ptb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      empty
);

  localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          entries [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = count == CW'(CMDQ_DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ptb_back.sv -----
// -----------------------------------------------------------------------------
// ptb_back
// Slot engine: keeps the service order and per-slot state, runs register
// and unregister commands, and walks the active slots on each tick.
// -----------------------------------------------------------------------------
`default_nettype none

module ptb_back import ptb_pkg::*; #(
  parameter int NSLOTS = DEF_NSLOTS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  input  cmd_t                   cmd,
  output logic                   cmd_pop,
  output logic                   fired,
  output logic [SLOT_W-1:0]      fired_slot,
  output logic [TAG_W-1:0]       fired_tag,
  output logic [TCNT_W-1:0]      tick_count,
  output logic                   last
);

  localparam int IDX_W = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int CNT_W = $clog2(NSLOTS + 1);
  localparam int CFG_W = TICK_W + TAG_W;

  back_state_t       state, state_next;
  logic [SLOT_W-1:0] order      [NSLOTS];
  logic [SLOT_W-1:0] order_next [NSLOTS];
  logic [SLOT_W-1:0] comp       [NSLOTS];
  logic [SLOT_W-1:0] base       [NSLOTS];
  logic [SLOT_W-1:0] ins        [NSLOTS];
  logic [NSLOTS-1:0] match;
  logic [NSLOTS-1:0] seen;
  logic [NSLOTS-1:0] active, active_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [TCNT_W-1:0] tick_counter, tick_counter_next;
  logic              rd_valid, rd_valid_next;
  logic [SLOT_W-1:0] rd_slot, rd_slot_next;
  logic              pend_valid, pend_valid_next;
  logic [SLOT_W-1:0] pend_slot, pend_slot_next;
  logic [TAG_W-1:0]  pend_tag, pend_tag_next;
  logic              fired_next;
  logic [SLOT_W-1:0] fired_slot_next;
  logic [TAG_W-1:0]  fired_tag_next;
  logic              last_next;

  logic [IDX_W-1:0]  cmd_idx;
  logic              cmd_active;
  logic              issue;
  logic [TICK_W-1:0] el_inc;
  logic              hit;

  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_rdata;
  logic              el_we;
  logic [IDX_W-1:0]  el_waddr;
  logic [TICK_W-1:0] el_wdata;
  logic [TICK_W-1:0] el_rdata;
  logic [IDX_W-1:0]  rd_addr;

  assign cmd_idx    = IDX_W'(cmd.slot);
  assign cmd_active = active[cmd_idx];
  assign rd_addr    = IDX_W'(order[idx[IDX_W-1:0]]);

  // removal closes the gap: entries after the match move up one place
  always_comb begin
    seen[0] = match[0];
    for (int i = 1; i < NSLOTS; i++) begin
      seen[i] = seen[i-1] | match[i];
    end
  end

  for (genvar g = 0; g < NSLOTS; g++) begin : g_order
    assign match[g] = order[g] == cmd.slot;
    if (g < NSLOTS - 1) begin : g_mid
      assign comp[g] = seen[g] ? order[g+1] : order[g];
    end else begin : g_end
      assign comp[g] = order[g];
    end
    assign base[g] = cmd_active ? comp[g] : order[g];
    if (g == 0) begin : g_head
      assign ins[g] = cmd.slot;
    end else begin : g_tail
      assign ins[g] = base[g-1];
    end
  end

  ptb_ram #(.WIDTH(CFG_W), .DEPTH(NSLOTS)) u_cfg_ram (
    .clk   (clk),
    .we    (cfg_we),
    .waddr (cmd_idx),
    .wdata ({cmd.ticks, cmd.tag}),
    .raddr (rd_addr),
    .rdata (cfg_rdata)
  );

  ptb_ram #(.WIDTH(TICK_W), .DEPTH(NSLOTS)) u_elapsed_ram (
    .clk   (clk),
    .we    (el_we),
    .waddr (el_waddr),
    .wdata (el_wdata),
    .raddr (rd_addr),
    .rdata (el_rdata)
  );

  assign issue  = idx != count;
  assign el_inc = el_rdata + 1'b1;
  assign hit    = el_inc == cfg_rdata[CFG_W-1:TAG_W];

  always_comb begin
    state_next        = state;
    order_next        = order;
    active_next       = active;
    count_next        = count;
    idx_next          = idx;
    tick_counter_next = tick_counter;
    rd_valid_next     = 1'b0;
    rd_slot_next      = rd_slot;
    pend_valid_next   = pend_valid;
    pend_slot_next    = pend_slot;
    pend_tag_next     = pend_tag;
    fired_next        = 1'b0;
    fired_slot_next   = fired_slot;
    fired_tag_next    = fired_tag;
    last_next         = 1'b0;
    cmd_pop           = 1'b0;
    cfg_we            = 1'b0;
    el_we             = 1'b0;
    el_waddr          = cmd_idx;
    el_wdata          = '0;

    unique case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            CMD_REG: begin
              order_next           = ins;
              count_next           = cmd_active ? count : count + 1'b1;
              active_next[cmd_idx] = 1'b1;
              cfg_we               = 1'b1;
              el_we                = 1'b1;
            end
            CMD_UNREG: begin
              if (cmd_active) begin
                order_next           = comp;
                count_next           = count - 1'b1;
                active_next[cmd_idx] = 1'b0;
              end
            end
            CMD_TICK: begin
              tick_counter_next = tick_counter + 1'b1;
              idx_next          = '0;
              if (count != '0) begin
                state_next = BK_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      BK_WALK: begin
        // read issued one cycle, compare and write back the next
        rd_valid_next = issue;
        if (issue) begin
          rd_slot_next = order[idx[IDX_W-1:0]];
          idx_next     = idx + 1'b1;
        end
        if (rd_valid) begin
          el_we    = 1'b1;
          el_waddr = IDX_W'(rd_slot);
          el_wdata = hit ? '0 : el_inc;
          if (hit) begin
            // hold each expiry until the next one shows it was not last
            if (pend_valid) begin
              fired_next      = 1'b1;
              fired_slot_next = pend_slot;
              fired_tag_next  = pend_tag;
            end
            pend_valid_next = 1'b1;
            pend_slot_next  = rd_slot;
            pend_tag_next   = cfg_rdata[TAG_W-1:0];
          end
        end
        if (!issue && !rd_valid) begin
          if (pend_valid) begin
            fired_next      = 1'b1;
            fired_slot_next = pend_slot;
            fired_tag_next  = pend_tag;
            last_next       = 1'b1;
          end
          pend_valid_next = 1'b0;
          state_next      = BK_IDLE;
        end
      end

      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      active       <= '0;
      count        <= '0;
      idx          <= '0;
      tick_counter <= '0;
      rd_valid     <= 1'b0;
      pend_valid   <= 1'b0;
      fired        <= 1'b0;
      last         <= 1'b0;
    end else begin
      state        <= state_next;
      active       <= active_next;
      count        <= count_next;
      idx          <= idx_next;
      tick_counter <= tick_counter_next;
      rd_valid     <= rd_valid_next;
      pend_valid   <= pend_valid_next;
      fired        <= fired_next;
      last         <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    order      <= order_next;
    rd_slot    <= rd_slot_next;
    pend_slot  <= pend_slot_next;
    pend_tag   <= pend_tag_next;
    fired_slot <= fired_slot_next;
    fired_tag  <= fired_tag_next;
  end

  assign tick_count = tick_counter;

endmodule

`default_nettype wire

// ----- rtl/core/ptb_checker.sv -----
// -----------------------------------------------------------------------------
// ptb_checker
// Port-level checks on the timer bank, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

`include "periodic_timer_bank_assert.svh"

module ptb_checker import ptb_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic [1:0]        operation,
  input wire logic              fired,
  input wire logic [TCNT_W-1:0] tick_count,
  input wire logic              last
);

  // no result right after a reset cycle
  `PTB_ASSERT_ALWAYS(a_no_fire_after_rst, clk, rst, !fired)

  // results of one tick all carry the same tick count
  `PTB_ASSERT_NOW(a_tick_stable, clk, rst, fired && $past(fired) && !$past(last), tick_count == $past(tick_count))

  // an accepted tick request makes the intake busy in the next cycle
  `PTB_ASSERT_NEXT(a_tick_busy, clk, rst, start && !busy && operation == OP_TICK, busy)

  // a marked last result is never followed at once by a result of the same tick
  `PTB_ASSERT_NEXT(a_last_gap, clk, rst, fired && last, !fired || tick_count != $past(tick_count))

endmodule

bind periodic_timer_bank ptb_checker u_ptb_checker (.*);

`default_nettype wire
